[rtl/bfra_pkg.sv]
// ----------------------------------------------------------------------------
// bfra_pkg
// Shared types and constants for the bounded fifo running average block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfra_pkg;

  localparam int TAG_W               = 16;
  localparam int VALUE_W             = 10;
  localparam int KIND_W              = 2;
  localparam int ENTRY_W             = TAG_W + VALUE_W;
  localparam int DEFAULT_QUEUE_DEPTH = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MEAN    = 2'd0,
    KIND_REMOVED = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  typedef struct packed {
    logic               opcode;
    logic [TAG_W-1:0]   entry_tag;
    logic [VALUE_W-1:0] sample_value;
  } req_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [VALUE_W-1:0] mean_value;
    logic [TAG_W-1:0]   removed_tag;
  } rsp_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

[rtl/bfra_store.sv]
// ----------------------------------------------------------------------------
// bfra_store
// Entry memory of the queue: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfra_store #(
  parameter int QUEUE_DEPTH = bfra_pkg::DEFAULT_QUEUE_DEPTH,
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [IDX_W-1:0]             wr_addr,
  input  wire logic [bfra_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0]             rd_addr,
  output logic      [bfra_pkg::ENTRY_W-1:0] rd_data
);
  import bfra_pkg::*;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/bfra_divider.sv]
// ----------------------------------------------------------------------------
// bfra_divider
// Restoring serial divider of sum by count, one quotient bit a cycle,
// followed by a round half to even step.
// ----------------------------------------------------------------------------
`default_nettype none

module bfra_divider #(
  parameter int QUEUE_DEPTH = bfra_pkg::DEFAULT_QUEUE_DEPTH,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int SUM_W = bfra_pkg::VALUE_W + CNT_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [SUM_W-1:0]             dividend,
  input  wire logic [CNT_W-1:0]             divisor,
  output logic                              done,
  output logic      [bfra_pkg::VALUE_W-1:0] mean
);
  import bfra_pkg::*;

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [ITER_W-1:0] iter;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  div;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;
  logic [CNT_W:0]    twice_rem;
  logic              round_up;

  always_comb begin
    shifted   = {rem, quo[SUM_W-1]};
    diff      = shifted - {1'b0, div};
    fits      = shifted >= {1'b0, div};
    twice_rem = {rem, 1'b0};
    round_up  = (twice_rem > {1'b0, div}) || ((twice_rem == {1'b0, div}) && quo[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(SUM_W);
        quo  <= dividend;
        rem  <= '0;
        div  <= divisor;
      end else if (busy) begin
        if (iter != '0) begin
          iter <= iter - 1'b1;
          if (fits) begin
            rem <= diff[CNT_W-1:0];
            quo <= {quo[SUM_W-2:0], 1'b1};
          end else begin
            rem <= shifted[CNT_W-1:0];
            quo <= {quo[SUM_W-2:0], 1'b0};
          end
        end else begin
          // quotient never exceeds the largest sample value
          mean <= quo[VALUE_W-1:0] + VALUE_W'(round_up);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bounded_fifo_running_average.sv]
// ----------------------------------------------------------------------------
// bounded_fifo_running_average
// Bounded queue of tagged samples with a running sum; an insert reports the
// rounded mean of the held samples, a remove reports the oldest tag (empty if none).
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    opcode, entry_tag, sample_value
//   rsp      out        rsp_valid/stall    result_kind, mean_value, removed_tag
//
// one item at a time; req_stall is high from acceptance until the result is
// taken. a remove goes from the exec state to the output state; an insert
// passes on through divider start and the wait for the serial divider first.
// the next item can be taken in the cycle after the result at the earliest.
// rsp_stall holds the result in its output register.
// reset clears head, count and sum; the entry memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_fifo_running_average #(
  parameter int QUEUE_DEPTH = bfra_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire bfra_pkg::req_item_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output bfra_pkg::rsp_item_t      rsp
);
  import bfra_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = VALUE_W + CNT_W;

  state_t             state;
  state_t             state_next;
  req_item_t          item;
  logic [IDX_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [SUM_W-1:0]   sum;
  logic [ENTRY_W-1:0] rd_data;
  logic               full;
  logic [IDX_W:0]     tail_raw;
  logic [IDX_W:0]     tail_wrap;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   head_inc;
  logic [SUM_W-1:0]   old_value;
  logic               wr_en;
  logic               div_start;
  logic               div_done;
  logic [VALUE_W-1:0] div_mean;

  always_comb begin
    full      = count == CNT_W'(QUEUE_DEPTH);
    tail_raw  = {1'b0, head} + (IDX_W + 1)'(count);
    tail_wrap = (tail_raw >= (IDX_W + 1)'(QUEUE_DEPTH))
                ? tail_raw - (IDX_W + 1)'(QUEUE_DEPTH) : tail_raw;
    tail      = tail_wrap[IDX_W-1:0];
    head_inc  = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    old_value = SUM_W'(rd_data[VALUE_W-1:0]);
    wr_en     = (state == ST_EXEC) && (item.opcode == OP_INSERT);
    div_start = state == ST_DIV_START;
    req_stall = state != ST_IDLE;
    rsp_valid = state == ST_OUT;
  end

  bfra_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(tail),
    .wr_data({item.entry_tag, item.sample_value}),
    .rd_addr(head),
    .rd_data(rd_data)
  );

  bfra_divider #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum),
    .divisor (count),
    .done    (div_done),
    .mean    (div_mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = (item.opcode == OP_INSERT) ? ST_DIV_START : ST_OUT;
      end
      ST_DIV_START: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      sum   <= '0;
    end else begin
      if (state == ST_EXEC) begin
        if (item.opcode == OP_INSERT) begin
          // when full the oldest item makes room for the new one
          sum <= sum - (full ? old_value : '0) + SUM_W'(item.sample_value);
          if (full) begin
            head <= head_inc;
          end else begin
            count <= count + 1'b1;
          end
        end else if (count != '0) begin
          sum   <= sum - old_value;
          head  <= head_inc;
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      item <= req;
    end
    if (state == ST_EXEC && item.opcode == OP_REMOVE) begin
      if (count == '0) begin
        rsp <= '{result_kind: KIND_EMPTY, mean_value: '0, removed_tag: '0};
      end else begin
        rsp <= '{result_kind: KIND_REMOVED, mean_value: '0,
                 removed_tag: rd_data[ENTRY_W-1:VALUE_W]};
      end
    end
    if (state == ST_DIV_WAIT && div_done) begin
      rsp <= '{result_kind: KIND_MEAN, mean_value: div_mean, removed_tag: '0};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (sum == '0))
    else $error("running sum not zero on empty queue");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider result outside wait state");

  a_empty_kind: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.result_kind == KIND_EMPTY) |-> (count == '0))
    else $error("empty result with items held");

endmodule

`default_nettype wire
